// ----- src/dtf_pkg.sv -----
// ---------------------------------------------------------------------------
// dtf_pkg
// Shared types, codes and constants of the decimal text to fixed point block.
// ---------------------------------------------------------------------------
`default_nettype none

package dtf_pkg;

    localparam int CHAR_W    = 8;
    localparam int DIGIT_W   = 4;
    localparam int VALUE_W   = 64;
    localparam int STATUS_W  = 2;
    localparam int Q_DEPTH   = 2;

    localparam int INT_BITS_DEF        = 31;
    localparam int FRAC_BITS_DEF       = 32;
    localparam int MAX_FRAC_DIGITS_DEF = 9;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'd46;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_PARSE = 2'd1,
        ST_NUL   = 2'd2,
        ST_OVF   = 2'd3
    } t_status;

    // character class decided by the front end
    typedef enum logic [2:0] {
        CLS_SKIP  = 3'd0,
        CLS_SIGN  = 3'd1,
        CLS_DIGIT = 3'd2,
        CLS_POINT = 3'd3,
        CLS_NUL   = 3'd4,
        CLS_BAD   = 3'd5
    } t_cls;

    typedef struct packed {
        t_cls               cls;
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } t_q_entry;

    // floor(2^frac_bits / 10^k), by repeated floor division by ten
    function automatic logic [VALUE_W-1:0] frac_weight(input int frac_bits, input int k);
        logic [VALUE_W-1:0] w;
        w = VALUE_W'(1) << frac_bits;
        for (int i = 0; i < k; i++) begin
            w = w / 10;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- src/dtf_front.sv -----
// ---------------------------------------------------------------------------
// dtf_front
// Accepts characters, tracks the start of each number and classifies them.
// ---------------------------------------------------------------------------
`default_nettype none

module dtf_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [dtf_pkg::CHAR_W-1:0]      i_char_code,
    input  wire logic                            i_char_valid,
    input  wire logic                            i_last_char,
    input  wire logic                            i_q_room,
    output logic                                 o_push,
    output dtf_pkg::t_q_entry                    o_entry
);

    logic r_at_start;
    logic n_at_start;
    logic w_is_digit;

    assign o_ready = i_q_room;
    assign o_push  = i_valid && i_q_room;

    assign w_is_digit = (i_char_code >= dtf_pkg::CH_ZERO) && (i_char_code <= dtf_pkg::CH_NINE);

    always_comb begin
        o_entry.last  = i_last_char;
        o_entry.digit = dtf_pkg::DIGIT_W'(i_char_code - dtf_pkg::CH_ZERO);
        if (!i_char_valid) begin
            o_entry.cls = dtf_pkg::CLS_SKIP;
        end else if (r_at_start && i_char_code == dtf_pkg::CH_MINUS) begin
            o_entry.cls = dtf_pkg::CLS_SIGN;
        end else if (i_char_code == dtf_pkg::CH_NUL) begin
            o_entry.cls = dtf_pkg::CLS_NUL;
        end else if (w_is_digit) begin
            o_entry.cls = dtf_pkg::CLS_DIGIT;
        end else if (i_char_code == dtf_pkg::CH_POINT) begin
            o_entry.cls = dtf_pkg::CLS_POINT;
        end else begin
            o_entry.cls = dtf_pkg::CLS_BAD;
        end
    end

    always_comb begin
        n_at_start = r_at_start;
        if (o_push) begin
            if (i_last_char) begin
                n_at_start = 1'b1;
            end else if (i_char_valid) begin
                n_at_start = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
        end else begin
            r_at_start <= n_at_start;
        end
    end

endmodule

`default_nettype wire

// ----- src/dtf_queue.sv -----
// ---------------------------------------------------------------------------
// dtf_queue
// Short queue of classified characters between front end and back end.
// ---------------------------------------------------------------------------
`default_nettype none

module dtf_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire dtf_pkg::t_q_entry i_entry,
    output logic                   o_room,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output dtf_pkg::t_q_entry      o_entry
);

    localparam int PTR_W = (dtf_pkg::Q_DEPTH > 1) ? $clog2(dtf_pkg::Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(dtf_pkg::Q_DEPTH + 1);

    dtf_pkg::t_q_entry r_slot [dtf_pkg::Q_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              w_push, w_pop;

    assign o_room  = (r_count < CNT_W'(dtf_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_slot[r_rd_ptr];
    assign w_push  = i_push && o_room;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(dtf_pkg::Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(dtf_pkg::Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(dtf_pkg::Q_DEPTH))
        else $error("queue count above depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a request");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

// ----- src/dtf_back.sv -----
// ---------------------------------------------------------------------------
// dtf_back
// Applies classified characters to the number state and registers the result.
// ---------------------------------------------------------------------------
`default_nettype none

module dtf_back #(
    parameter int INT_BITS        = dtf_pkg::INT_BITS_DEF,
    parameter int FRAC_BITS       = dtf_pkg::FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = dtf_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_valid,
    input  wire dtf_pkg::t_q_entry             i_entry,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [dtf_pkg::VALUE_W-1:0]        o_value,
    output logic [dtf_pkg::STATUS_W-1:0]       o_status
);

    localparam int VW    = dtf_pkg::VALUE_W;
    localparam int DW    = dtf_pkg::DIGIT_W;
    localparam int CNT_W = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int TBL_N = 2 ** CNT_W;
    localparam logic [VW-1:0] SAT_MAG = (VW'(1) << (INT_BITS + FRAC_BITS)) - VW'(1);
    localparam logic [INT_BITS-1:0] INT_MAX = {INT_BITS{1'b1}};

    logic [INT_BITS-1:0]  r_int, n_int;
    logic [FRAC_BITS-1:0] r_frac, n_frac;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_point, n_point;
    logic                 r_neg, n_neg;
    dtf_pkg::t_status     r_st, n_st;

    logic                 r_out_valid;
    logic [VW-1:0]        r_value;
    dtf_pkg::t_status     r_status;

    logic [FRAC_BITS-1:0]   w_weight [TBL_N];
    logic [FRAC_BITS+DW-1:0] w_prod;
    logic [INT_BITS+DW-1:0]  w_int_next;
    logic                    w_halted;
    logic [VW-1:0]           w_mag;
    logic [VW-1:0]           w_value;

    // weight of fraction digit k+1 sits at entry k
    for (genvar k = 0; k < TBL_N; k++) begin : g_weight
        localparam logic [VW-1:0] WFULL = dtf_pkg::frac_weight(FRAC_BITS, k + 1);
        assign w_weight[k] = WFULL[FRAC_BITS-1:0];
    end

    assign w_prod = {{FRAC_BITS{1'b0}}, i_entry.digit} * {{DW{1'b0}}, w_weight[r_cnt]};
    assign w_int_next = ({{DW{1'b0}}, r_int} << 3) + ({{DW{1'b0}}, r_int} << 1)
                      + {{INT_BITS{1'b0}}, i_entry.digit};
    assign w_halted = (r_st == dtf_pkg::ST_PARSE) || (r_st == dtf_pkg::ST_NUL);

    // a last entry waits while the output register is still held
    assign o_pop = i_q_valid && (!i_entry.last || !r_out_valid || i_ready);

    always_comb begin
        n_int   = r_int;
        n_frac  = r_frac;
        n_cnt   = r_cnt;
        n_point = r_point;
        n_neg   = r_neg;
        n_st    = r_st;
        if (!w_halted) begin
            case (i_entry.cls)
                dtf_pkg::CLS_SIGN: begin
                    n_neg = 1'b1;
                end
                dtf_pkg::CLS_NUL: begin
                    n_st = dtf_pkg::ST_NUL;
                end
                dtf_pkg::CLS_BAD: begin
                    n_st = dtf_pkg::ST_PARSE;
                end
                dtf_pkg::CLS_POINT: begin
                    if (r_point) begin
                        n_st = dtf_pkg::ST_PARSE;
                    end else begin
                        n_point = 1'b1;
                    end
                end
                dtf_pkg::CLS_DIGIT: begin
                    if (r_point) begin
                        if (r_cnt < CNT_W'(MAX_FRAC_DIGITS)) begin
                            n_cnt  = r_cnt + 1'b1;
                            n_frac = r_frac + w_prod[FRAC_BITS-1:0];
                        end
                    end else if (|w_int_next[INT_BITS+DW-1:INT_BITS]) begin
                        n_int = INT_MAX;
                        n_st  = dtf_pkg::ST_OVF;
                    end else begin
                        n_int = w_int_next[INT_BITS-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (n_st)
            dtf_pkg::ST_PARSE, dtf_pkg::ST_NUL: w_mag = '0;
            dtf_pkg::ST_OVF:                    w_mag = SAT_MAG;
            default: w_mag = (VW'(n_int) << FRAC_BITS) | VW'(n_frac);
        endcase
        w_value = n_neg ? (~w_mag + VW'(1)) : w_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int       <= '0;
            r_frac      <= '0;
            r_cnt       <= '0;
            r_point     <= 1'b0;
            r_neg       <= 1'b0;
            r_st        <= dtf_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && i_entry.last) begin
                r_int   <= '0;
                r_frac  <= '0;
                r_cnt   <= '0;
                r_point <= 1'b0;
                r_neg   <= 1'b0;
                r_st    <= dtf_pkg::ST_OK;
            end else if (o_pop) begin
                r_int   <= n_int;
                r_frac  <= n_frac;
                r_cnt   <= n_cnt;
                r_point <= n_point;
                r_neg   <= n_neg;
                r_st    <= n_st;
            end
            if (o_pop && i_entry.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.last) begin
            r_value  <= w_value;
            r_status <= n_st;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_value  = r_value;
    assign o_status = r_status;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == dtf_pkg::ST_PARSE || r_status == dtf_pkg::ST_NUL))
        |-> (r_value == '0))
        else $error("error result with nonzero value");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == dtf_pkg::ST_OVF)
        |-> (r_value == SAT_MAG || r_value == (~SAT_MAG + VW'(1))))
        else $error("overflow result not saturated");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_FRAC_DIGITS))
        else $error("fraction digit count past limit");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_entry.last) |=> (r_int == '0 && r_cnt == '0 && !r_point && !r_neg
                                      && r_st == dtf_pkg::ST_OK && r_out_valid))
        else $error("number state not cleared after last character");

endmodule

`default_nettype wire

// ----- src/decimal_text_to_fixed.sv -----
// ---------------------------------------------------------------------------
// decimal_text_to_fixed
// ASCII decimal text to signed fixed point, one character per request.
// ---------------------------------------------------------------------------
// One character is taken every clock cycle while the queue has room, and one
// result can leave every cycle. A character goes into a two-entry queue in the
// cycle it is taken and is applied to the number state when it is popped from
// the head of the queue; a final character loads the output register as it is
// popped, which raises o_valid. The per-character update is one times-ten
// shift-add on the integer part or one digit times weight product on the
// fraction part; the final character also adds the two's complement negate.
// No clearing pass follows reset.
`default_nettype none

module decimal_text_to_fixed #(
    parameter int INT_BITS        = dtf_pkg::INT_BITS_DEF,
    parameter int FRAC_BITS       = dtf_pkg::FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = dtf_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic [dtf_pkg::CHAR_W-1:0]           i_char_code,
    input  wire logic                                 i_char_valid,
    input  wire logic                                 i_last_char,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic signed [dtf_pkg::VALUE_W-1:0]        o_value_fixed,
    output logic [dtf_pkg::STATUS_W-1:0]              o_status
);

    dtf_pkg::t_q_entry                w_push_entry;
    dtf_pkg::t_q_entry                w_head_entry;
    logic                             w_push;
    logic                             w_room;
    logic                             w_head_valid;
    logic                             w_pop;
    logic [dtf_pkg::VALUE_W-1:0]      w_value;

    dtf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_char_code  (i_char_code),
        .i_char_valid (i_char_valid),
        .i_last_char  (i_last_char),
        .i_q_room     (w_room),
        .o_push       (w_push),
        .o_entry      (w_push_entry)
    );

    dtf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_room  (w_room),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_entry (w_head_entry)
    );

    dtf_back #(
        .INT_BITS        (INT_BITS),
        .FRAC_BITS       (FRAC_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_head_valid),
        .i_entry   (w_head_entry),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_value   (w_value),
        .o_status  (o_status)
    );

    assign o_value_fixed = $signed(w_value);

endmodule

`default_nettype wire
